// ===== rtl/core/lpbu_pkg.sv =====
// ----------------------------------------------------------------------------
// lpbu_pkg
// Shared types and constants of the length-prefixed byte unstuffer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpbu_pkg;

    localparam int LPBU_BYTE_W   = 8;
    localparam int LPBU_LEN_W    = 16;
    localparam int LPBU_CODE_W   = 2;

    // result queue; depth must be a power of two and hold at least two entries
    localparam int LPBU_Q_DEPTH  = 4;
    localparam int LPBU_Q_PTR_W  = $clog2(LPBU_Q_DEPTH);
    localparam int LPBU_Q_CNT_W  = $clog2(LPBU_Q_DEPTH + 1);

    localparam logic [LPBU_BYTE_W-1:0] LPBU_ZERO_MARKER = 8'h00;
    localparam logic [LPBU_BYTE_W-1:0] LPBU_END_MARKER  = 8'hFF;
    localparam logic [LPBU_LEN_W-1:0]  LPBU_CAP_RESET   = 16'hFFFF;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        PH_MARKER = 2'd0,
        PH_CHUNK  = 2'd1,
        PH_DONE   = 2'd2,
        PH_ERROR  = 2'd3
    } t_phase;

    typedef enum logic [LPBU_CODE_W-1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_TRUNC = 2'd2,
        ST_CAP   = 2'd3
    } t_status;

    typedef struct packed {
        logic                   kind;
        logic [LPBU_BYTE_W-1:0] data;
        logic [LPBU_CODE_W-1:0] code;
        logic [LPBU_LEN_W-1:0]  len;
        logic                   last_of_run;
    } t_result;

    // results produced by one accepted request, first in r0
    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/core/lpbu_if.sv =====
// ----------------------------------------------------------------------------
// lpbu_in_if / lpbu_out_if
// Valid/ready channels for stuffed input bytes and recovered results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpbu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lpbu_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  out_byte;
    logic [1:0]  status_code;
    logic [15:0] frame_length;
    logic        last_of_run;

    modport source (output valid, output item_kind, output out_byte,
                    output status_code, output frame_length,
                    output last_of_run, input ready);
    modport sink   (input valid, input item_kind, input out_byte,
                    input status_code, input frame_length,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/length_prefixed_byte_unstuffer.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_byte_unstuffer
// Streaming deframer for length-prefixed stuffed frames.
// ----------------------------------------------------------------------------
// Takes one stuffed byte per cycle while i_in.ready is high. A byte is
// decoded in the cycle it is accepted and its results (none, a data byte,
// an end-of-frame status, or both) are registered into a four-entry result
// queue, which offers them on o_out in order. i_in.ready is high while the
// queue has at least two free entries, so with o_out.ready held high the
// block sustains one request per cycle; the final byte of a frame that also
// carries data yields two results, which leave the queue one at a time. Data
// bytes are delivered before the frame status is known: discard a frame's
// data when its status is not ok. output_capacity is written through
// i_cfg_wr_en/i_cfg_wr_data and applies from the next chunk marker.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_byte_unstuffer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [lpbu_pkg::LPBU_LEN_W-1:0] i_cfg_wr_data,
    lpbu_in_if.sink                              i_in,
    lpbu_out_if.source                           o_out
);
    import lpbu_pkg::*;

    logic    w_accept;
    logic    w_room;
    t_push   w_push;
    t_result w_head;

    // hold off requests while reset is applied
    assign i_in.ready = w_room && i_rst_n;
    assign w_accept   = i_in.valid && i_in.ready;

    lpbu_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_byte        (i_in.in_byte),
        .i_last        (i_in.in_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (w_push)
    );

    lpbu_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_out.valid),
        .o_head  (w_head),
        .i_pop   (o_out.ready)
    );

    assign o_out.item_kind    = w_head.kind;
    assign o_out.out_byte     = w_head.data;
    assign o_out.status_code  = w_head.code;
    assign o_out.frame_length = w_head.len;
    assign o_out.last_of_run  = w_head.last_of_run;

endmodule

`default_nettype wire

// ===== rtl/core/lpbu_frame.sv =====
// ----------------------------------------------------------------------------
// lpbu_frame
// Frame state and per-byte decode: turns one stuffed byte into zero, one or
// two results.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbu_frame (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [lpbu_pkg::LPBU_BYTE_W-1:0] i_byte,
    input  wire logic                        i_last,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [lpbu_pkg::LPBU_LEN_W-1:0]  i_cfg_wr_data,
    output lpbu_pkg::t_push                  o_push
);
    import lpbu_pkg::*;

    t_phase                 r_phase, n_phase, s_phase;
    logic [LPBU_BYTE_W-1:0] r_remaining, n_remaining, s_remaining;
    logic [LPBU_LEN_W-1:0]  r_count, n_count, s_count;
    t_status                r_error, n_error, s_error;
    logic [LPBU_LEN_W-1:0]  r_capacity;

    logic                   w_emit;
    logic [LPBU_LEN_W:0]    w_sum;
    t_status                w_code;

    assign w_emit = (r_phase == PH_CHUNK) && (r_error == ST_OK);
    assign w_sum  = {1'b0, r_count} + {{(LPBU_LEN_W-LPBU_BYTE_W+1){1'b0}}, i_byte};

    // effect of the byte itself, before frame end is applied
    always_comb begin
        s_phase     = r_phase;
        s_remaining = r_remaining;
        s_count     = r_count;
        s_error     = r_error;
        case (r_phase)
            PH_MARKER: begin
                if (i_byte == LPBU_ZERO_MARKER) begin
                    s_error = ST_ZERO;
                    s_phase = PH_ERROR;
                end else if (i_byte == LPBU_END_MARKER) begin
                    s_phase = PH_DONE;
                end else begin
                    if (w_sum > {1'b0, r_capacity}) begin
                        s_error = ST_CAP;
                    end
                    s_remaining = i_byte;
                    s_phase     = PH_CHUNK;
                end
            end
            PH_CHUNK: begin
                if (w_emit) begin
                    s_count = r_count + LPBU_LEN_W'(1);
                end
                s_remaining = r_remaining - LPBU_BYTE_W'(1);
                if (s_remaining == '0) begin
                    s_phase = (r_error != ST_OK) ? PH_ERROR : PH_MARKER;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (s_phase)
            PH_CHUNK: w_code = ST_TRUNC;
            PH_ERROR: w_code = s_error;
            default:  w_code = ST_OK;
        endcase
    end

    // next state: frame end clears everything
    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_count     = r_count;
        n_error     = r_error;
        if (i_accept) begin
            if (i_last) begin
                n_phase     = PH_MARKER;
                n_remaining = '0;
                n_count     = '0;
                n_error     = ST_OK;
            end else begin
                n_phase     = s_phase;
                n_remaining = s_remaining;
                n_count     = s_count;
                n_error     = s_error;
            end
        end
    end

    // results of this request
    always_comb begin
        t_result data_res;
        t_result stat_res;
        data_res             = '0;
        data_res.kind        = KIND_DATA;
        data_res.data        = i_byte;
        data_res.last_of_run = !i_last;
        stat_res             = '0;
        stat_res.kind        = KIND_STATUS;
        stat_res.code        = w_code;
        stat_res.len         = (w_code == ST_OK) ? s_count : '0;
        stat_res.last_of_run = 1'b1;

        o_push     = '0;
        o_push.num = i_accept ? ({1'b0, w_emit} + {1'b0, i_last}) : 2'd0;
        o_push.r0  = w_emit ? data_res : stat_res;
        o_push.r1  = stat_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MARKER;
            r_remaining <= '0;
            r_count     <= '0;
            r_error     <= ST_OK;
            r_capacity  <= LPBU_CAP_RESET;
        end else begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_count     <= n_count;
            r_error     <= n_error;
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
        end
    end

    a_chunk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CHUNK) |-> (r_remaining != '0))
        else $error("chunk phase with no bytes remaining");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_phase == PH_MARKER && r_count == '0
                                  && r_error == ST_OK))
        else $error("frame state not cleared after final byte");

    a_error_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) |-> (r_error != ST_OK))
        else $error("error phase without an error code");

endmodule

`default_nettype wire

// ===== rtl/core/lpbu_res_fifo.sv =====
// ----------------------------------------------------------------------------
// lpbu_res_fifo
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbu_res_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lpbu_pkg::t_push  i_push,
    output logic                  o_room,
    output logic                  o_valid,
    output lpbu_pkg::t_result     o_head,
    input  wire logic             i_pop
);
    import lpbu_pkg::*;

    t_result                 r_mem [LPBU_Q_DEPTH];
    logic [LPBU_Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [LPBU_Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [LPBU_Q_CNT_W-1:0] r_count, n_count;
    logic                    w_pop;
    logic [LPBU_Q_PTR_W-1:0] w_wr_ptr1;

    assign o_valid   = (r_count != '0);
    assign o_head    = r_mem[r_rd_ptr];
    assign o_room    = (r_count <= LPBU_Q_CNT_W'(LPBU_Q_DEPTH - 2));
    assign w_pop     = i_pop && o_valid;
    assign w_wr_ptr1 = r_wr_ptr + LPBU_Q_PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + LPBU_Q_PTR_W'(i_push.num);
        n_rd_ptr = r_rd_ptr + LPBU_Q_PTR_W'(w_pop);
        n_count  = r_count + LPBU_Q_CNT_W'(i_push.num) - LPBU_Q_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LPBU_Q_CNT_W'(LPBU_Q_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != 2'd0) |-> o_room)
        else $error("results pushed without room");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == LPBU_Q_CNT_W'(LPBU_Q_DEPTH))
            |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire
